/* hdl/mrsfb_pkg.sv */
// Shared types, frame constants and the CRC-16/MODBUS byte update.
package mrsfb_pkg;

   localparam int FRAME_LEN = 8;
   localparam int MSG_LEN   = 6;
   localparam int CNT_W     = $clog2(FRAME_LEN);
   localparam int CSR_IDX_W = 8;

   localparam logic [CSR_IDX_W-1:0] REG_PORT_OPEN      = 8'd0;
   localparam logic [CSR_IDX_W-1:0] REG_DEVICE_ADDRESS = 8'd1;

   localparam logic [7:0] DEVICE_ADDRESS_RESET = 8'h01;

   localparam logic [7:0] FUNC_WRITE_COIL = 8'h05;
   localparam logic [7:0] FUNC_WRITE_REG  = 8'h06;
   localparam logic [7:0] COIL_ADDR_HI    = 8'h01;
   localparam logic [7:0] COIL_START_LO   = 8'h60;
   localparam logic [7:0] COIL_STOP_LO    = 8'h61;
   localparam logic [7:0] COIL_VALUE_HI   = 8'hFF;
   localparam logic [7:0] COIL_VALUE_LO   = 8'h00;
   localparam logic [7:0] SETPOINT_HI     = 8'h00;
   localparam logic [7:0] SETPOINT_LO     = 8'h64;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   typedef struct packed {
      logic [MSG_LEN-1:0][7:0] msg;
      logic [15:0]             crc;
   } frame_type;

   typedef struct packed {
      logic       port_open;
      logic [7:0] device_address;
   } cfg_type;

   function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] data);
      logic [15:0] crc;
      crc = crc_in ^ {8'h00, data};
      for (int b = 0; b < 8; b++) begin
         if (crc[0]) crc = (crc >> 1) ^ CRC_POLY;
         else        crc = crc >> 1;
      end
      return crc;
   endfunction

endpackage

/* hdl/mrsfb_ifs.sv */
// Valid/ready channel interfaces: request, response and register write.
interface mrsfb_req_if;
   logic               valid;
   logic               ready;
   logic               command;
   logic               coil_on;
   logic signed [15:0] temp_centi;
   modport source (output valid, command, coil_on, temp_centi, input ready);
   modport sink   (input valid, command, coil_on, temp_centi, output ready);
endinterface

interface mrsfb_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] frame_byte;
   logic       last;
   modport source (output valid, frame_byte, last, input ready);
   modport sink   (input valid, frame_byte, last, output ready);
endinterface

interface mrsfb_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] index;
   logic [7:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

/* hdl/mrsfb_builder.sv */
// First pipeline stage: assembles the six message bytes of a request.
module mrsfb_builder
   import mrsfb_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  cfg_type            cfg,
   input  logic               in_valid,
   output logic               in_ready,
   input  logic               command,
   input  logic               coil_on,
   input  logic signed [15:0] temp_centi,
   output logic               out_valid,
   input  logic               out_ready,
   output frame_type          out_data
);

   logic      valid_ff;
   frame_type data_ff, data_in;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      data_in.crc    = CRC_INIT;
      data_in.msg[0] = cfg.device_address;
      if (!command) begin
         data_in.msg[1] = FUNC_WRITE_COIL;
         data_in.msg[2] = COIL_ADDR_HI;
         data_in.msg[3] = coil_on ? COIL_START_LO : COIL_STOP_LO;
         data_in.msg[4] = COIL_VALUE_HI;
         data_in.msg[5] = COIL_VALUE_LO;
      end else begin
         data_in.msg[1] = FUNC_WRITE_REG;
         data_in.msg[2] = SETPOINT_HI;
         data_in.msg[3] = SETPOINT_LO;
         data_in.msg[4] = temp_centi[15:8];
         data_in.msg[5] = temp_centi[7:0];
      end
   end

   // a request taken while the port is closed is simply dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid && cfg.port_open;
      end
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

/* hdl/mrsfb_crc_stage.sv */
// One CRC pipeline stage: folds one message byte into the running CRC.
module mrsfb_crc_stage
   import mrsfb_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   output logic      in_ready,
   input  frame_type in_data,
   input  logic [7:0] crc_data,
   output logic      out_valid,
   input  logic      out_ready,
   output frame_type out_data
);

   logic      valid_ff;
   frame_type data_ff, data_in;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      data_in     = in_data;
      data_in.crc = crc_byte(in_data.crc, crc_data);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

/* hdl/mrsfb_serializer.sv */
// Output stage: sends the eight frame bytes one per response, CRC low byte first.
module mrsfb_serializer
   import mrsfb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  frame_type   in_data,
   output logic        out_valid,
   input  logic        out_ready,
   output logic [7:0]  out_byte,
   output logic        out_last,
   output logic [CNT_W-1:0] byte_count
);

   localparam logic [CNT_W-1:0] LAST_BYTE = CNT_W'(FRAME_LEN - 1);

   logic                          busy_ff;
   logic [CNT_W-1:0]              count_ff;
   logic [FRAME_LEN-1:0][7:0]     frame_ff;
   logic                          last_byte;

   assign last_byte  = (count_ff == LAST_BYTE);
   assign in_ready   = !busy_ff || (out_ready && last_byte);
   assign out_valid  = busy_ff;
   assign out_byte   = frame_ff[count_ff];
   assign out_last   = last_byte;
   assign byte_count = count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         count_ff <= '0;
      end else if (in_valid && in_ready) begin
         busy_ff  <= 1'b1;
         count_ff <= '0;
      end else if (busy_ff && out_ready) begin
         if (last_byte) busy_ff <= 1'b0;
         count_ff <= count_ff + 1'b1;
      end
      if (in_valid && in_ready) begin
         frame_ff <= {in_data.crc[15:8], in_data.crc[7:0], in_data.msg};
      end
   end

endmodule

/* hdl/modbus_rtu_setpoint_frame_builder.sv */
// Each accepted request with the port open gives eight response bytes (the last flagged);
// sustained throughput is set by the byte-wide output serializer, which takes the next frame
// as the last byte of the previous one is taken. Requests taken while port_open is 0
// are dropped. The pipeline is a builder stage, six CRC stages (one message byte each) and
// the serializer, so up to eight requests can be queued behind a stalled response channel.
module modbus_rtu_setpoint_frame_builder
   import mrsfb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   mrsfb_req_if.sink   req_chan,
   mrsfb_rsp_if.source rsp_chan,
   mrsfb_csr_if.sink   csr_chan
);

   cfg_type cfg_ff;

   logic      stg_valid [MSG_LEN+1];
   logic      stg_ready [MSG_LEN+1];
   frame_type stg_data  [MSG_LEN+1];
   logic [CNT_W-1:0] byte_count;

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.port_open      <= 1'b0;
         cfg_ff.device_address <= DEVICE_ADDRESS_RESET;
      end else if (csr_chan.valid) begin
         case (csr_chan.index)
            REG_PORT_OPEN:      cfg_ff.port_open      <= csr_chan.data[0];
            REG_DEVICE_ADDRESS: cfg_ff.device_address <= csr_chan.data;
            default: ;
         endcase
      end
   end

   mrsfb_builder u_builder (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .in_valid   (req_chan.valid),
      .in_ready   (req_chan.ready),
      .command    (req_chan.command),
      .coil_on    (req_chan.coil_on),
      .temp_centi (req_chan.temp_centi),
      .out_valid  (stg_valid[0]),
      .out_ready  (stg_ready[0]),
      .out_data   (stg_data[0])
   );

   for (genvar g = 0; g < MSG_LEN; g++) begin : g_crc
      mrsfb_crc_stage u_crc (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (stg_valid[g]),
         .in_ready  (stg_ready[g]),
         .in_data   (stg_data[g]),
         .crc_data  (stg_data[g].msg[g]),
         .out_valid (stg_valid[g+1]),
         .out_ready (stg_ready[g+1]),
         .out_data  (stg_data[g+1])
      );
   end

   mrsfb_serializer u_serializer (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (stg_valid[MSG_LEN]),
      .in_ready   (stg_ready[MSG_LEN]),
      .in_data    (stg_data[MSG_LEN]),
      .out_valid  (rsp_chan.valid),
      .out_ready  (rsp_chan.ready),
      .out_byte   (rsp_chan.frame_byte),
      .out_last   (rsp_chan.last),
      .byte_count (byte_count)
   );

   // closed port: the request never enters the pipeline
   a_drop_closed: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready && !cfg_ff.port_open |=> !stg_valid[0])
      else $error("request entered pipeline while port closed");

   // after the final byte the next frame starts from byte zero
   a_last_wraps: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.ready && rsp_chan.last |=> byte_count == '0)
      else $error("byte counter did not wrap after last byte");

   // a response byte moves on only when taken
   a_count_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.ready |=> $stable(byte_count))
      else $error("byte counter moved while response stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_chan.valid && !stg_valid[MSG_LEN])
      else $error("pipeline not empty after reset");

endmodule
